[sv/i2cdws_pkg.sv]
// ----------------------------------------------------------------------------
// i2cdws_pkg
// Shared types and constants for the I2C display write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cdws_pkg;

	// Request kinds, carried in the low bits of the input tuser
	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_RAW   = 2'd2,
		KIND_BURST = 2'd3
	} kind_t;

	// Bus symbol codes
	typedef enum logic [2:0] {
		SYM_START   = 3'd0,
		SYM_BIT     = 3'd1,
		SYM_ACK_REL = 3'd2,
		SYM_ACK_LOW = 3'd3,
		SYM_STOP    = 3'd4
	} sym_t;

	// Which byte feeds the data-bit mux
	typedef enum logic [1:0] {
		SEL_ADDR     = 2'd0,
		SEL_CTRL_CMD = 2'd1,
		SEL_CTRL_DAT = 2'd2,
		SEL_PAYLOAD  = 2'd3
	} byte_sel_t;

	localparam logic [7:0] ADDR_RESET = 8'h78;
	localparam logic [7:0] CTRL_CMD   = 8'h00;
	localparam logic [7:0] CTRL_DATA  = 8'h40;

	// Controller to datapath
	typedef struct packed {
		logic      capture;  // latch payload of the accepted item
		logic      emit;     // load output register with a symbol
		sym_t      sym;
		byte_sel_t sel;
		logic [2:0] bit_idx; // 0 = msb
		logic      eor;      // last symbol of this item
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;      // output register can take a symbol
	} dp_stat_t;

endpackage : i2cdws_pkg

`default_nettype wire

[sv/i2cdws_dp.sv]
// ----------------------------------------------------------------------------
// i2cdws_dp
// Datapath: address register, payload latch, bit mux and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cdws_dp
	import i2cdws_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [7:0] cfg_data,
	input  wire logic [7:0] payload,
	input  wire ctl_cmd_t   cmd,
	output dp_stat_t        stat,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      out_sym,
	output logic            out_bit,
	output logic            out_eor
);

	logic [7:0] addr_q;
	logic [7:0] payload_q;
	logic       valid_q;
	logic [2:0] sym_q;
	logic       bit_q;
	logic       eor_q;
	logic [7:0] cur_byte;
	logic       cur_bit;

	always_comb begin
		unique case (cmd.sel)
			SEL_ADDR:     cur_byte = addr_q;
			SEL_CTRL_CMD: cur_byte = CTRL_CMD;
			SEL_CTRL_DAT: cur_byte = CTRL_DATA;
			SEL_PAYLOAD:  cur_byte = payload_q;
			default:      cur_byte = payload_q;
		endcase
	end

	// msb first: index 0 picks bit 7
	assign cur_bit = (cmd.sym == SYM_BIT) ? cur_byte[~cmd.bit_idx] : 1'b0;

	assign stat.out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= ADDR_RESET;
			valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				addr_q <= cfg_data;
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			payload_q <= payload;
		end
		if (cmd.emit) begin
			sym_q <= cmd.sym;
			bit_q <= cur_bit;
			eor_q <= cmd.eor;
		end
	end

	assign out_valid = valid_q;
	assign out_sym   = sym_q;
	assign out_bit   = bit_q;
	assign out_eor   = eor_q;

endmodule : i2cdws_dp

`default_nettype wire

[sv/i2cdws_ctrl.sv]
// ----------------------------------------------------------------------------
// i2cdws_ctrl
// Controller: walks the symbol sequence of one request, one symbol a cycle while the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cdws_ctrl
	import i2cdws_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] in_kind,
	input  wire logic       in_first,
	input  wire logic       in_last,
	input  wire dp_stat_t   stat,
	output ctl_cmd_t        cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_ADDR,
		ST_ACK1,
		ST_CTRL,
		ST_ACK2,
		ST_DATA,
		ST_ACKF,
		ST_STOP
	} state_t;

	state_t     state_q;
	logic [2:0] bit_cnt_q;
	kind_t      kind_q;
	logic       last_q;
	logic       accept;
	logic       burst_open; // burst byte that leaves the bus open

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign burst_open = (kind_q == KIND_BURST) && !last_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.emit    = (state_q != ST_IDLE) && stat.out_free;
		cmd.bit_idx = bit_cnt_q;
		cmd.sel     = SEL_PAYLOAD;
		cmd.sym     = SYM_BIT;
		unique case (state_q)
			ST_IDLE:  cmd.sym = SYM_START;
			ST_START: cmd.sym = SYM_START;
			ST_ADDR:  cmd.sel = SEL_ADDR;
			ST_ACK1:  cmd.sym = SYM_ACK_REL;
			ST_CTRL:  cmd.sel = (kind_q == KIND_CMD) ? SEL_CTRL_CMD : SEL_CTRL_DAT;
			ST_ACK2:  cmd.sym = SYM_ACK_REL;
			ST_DATA:  cmd.sel = SEL_PAYLOAD;
			ST_ACKF: begin
				cmd.sym = (kind_q == KIND_CMD) ? SYM_ACK_LOW : SYM_ACK_REL;
				cmd.eor = burst_open;
			end
			ST_STOP: begin
				cmd.sym = SYM_STOP;
				cmd.eor = 1'b1;
			end
			default: cmd.sym = SYM_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			kind_q    <= KIND_CMD;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q    <= kind_t'(in_kind);
						last_q    <= in_last;
						bit_cnt_q <= '0;
						if (kind_t'(in_kind) == KIND_BURST && !in_first) begin
							state_q <= ST_DATA;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if (cmd.emit) begin
						state_q <= (kind_q == KIND_RAW) ? ST_DATA : ST_ADDR;
					end
				end
				ST_ADDR, ST_CTRL, ST_DATA: begin
					if (cmd.emit) begin
						bit_cnt_q <= bit_cnt_q + 3'd1;
						if (bit_cnt_q == 3'd7) begin
							unique case (state_q)
								ST_ADDR: state_q <= ST_ACK1;
								ST_CTRL: state_q <= ST_ACK2;
								default: state_q <= ST_ACKF;
							endcase
						end
					end
				end
				ST_ACK1: begin
					if (cmd.emit) begin
						state_q <= ST_CTRL;
					end
				end
				ST_ACK2: begin
					if (cmd.emit) begin
						state_q <= ST_DATA;
					end
				end
				ST_ACKF: begin
					if (cmd.emit) begin
						state_q <= burst_open ? ST_IDLE : ST_STOP;
					end
				end
				ST_STOP: begin
					if (cmd.emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : i2cdws_ctrl

`default_nettype wire

[sv/i2c_display_write_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_display_write_sequencer
// Write-only I2C master sequencer: one write request in, its bus symbols out.
// ----------------------------------------------------------------------------
// Start: accepting an item moves the controller out of idle; it then loads
//   the first symbol into the output register, from which it can be taken.
// Throughput: one symbol per cycle while the symbol side takes them; an item
//   is 29 symbols for command/data, 11 for raw and 9 to 29 for a burst byte.
//   The controller returns to idle after each item and only then accepts the
//   next, and a symbol the symbol side holds back stalls the controller.
// Reset: arst_n clears the sequencer to idle, empties the output register
//   and reloads device_address with 0x78.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_display_write_sequencer
	import i2cdws_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration: device_address (address byte with write bit)
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	// request stream
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] payload
	input  wire logic [2:0] s_axis_tuser,   // [1:0] kind, [2] first_of_burst
	input  wire logic       s_axis_tlast,   // last_of_burst
	// symbol stream
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [0] bit_value, [7:1] zero
	output logic [2:0]      m_axis_tuser,   // [2:0] symbol
	output logic            m_axis_tlast    // end_of_run
);

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     bit_value;

	// the user must make register writes only while idle; the block does not enforce this and is always ready
	assign cfg_ready = 1'b1;

	// Controller: sequences start, address, control, data, acks and stop.
	// Burst bytes without the first flag skip the header; without the last
	// flag they end on the data ack and leave the bus open.
	i2cdws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser[1:0]),
		.in_first (s_axis_tuser[2]),
		.in_last  (s_axis_tlast),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: holds address and payload, picks the bit, output register
	// decouples the symbol stream from the sequencer.
	i2cdws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.payload   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sym   (m_axis_tuser),
		.out_bit   (bit_value),
		.out_eor   (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, bit_value};

endmodule : i2c_display_write_sequencer

`default_nettype wire

[tb/sv/tb_i2c_display_write_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_i2c_display_write_sequencer
// Self-checking bench for the I2C display write sequencer: directed table of
// requests with golden symbol strings, then random phases with well-formed
// bursts, single writes and flag noise, each phase at a new device address.
// Every symbol item is checked against its golden string or an in-bench symbol predictor.
// ----------------------------------------------------------------------------
module tb_i2c_display_write_sequencer
	import i2cdws_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PHASES  = 5;
	localparam int PHASE_ITEMS  = 18;
	localparam int IDLE_PERCENT = 14;
	localparam int DRAIN_CYCLES = 8;   // margin after the output register has drained

	// one bus symbol as it should appear on the master side
	typedef struct packed {
		sym_t sym;
		logic bitv;
		logic eor;
	} bus_sym_t;

	// directed row: either a device address write or one request;
	// golden holds the symbol string when it can be read off directly
	// (S start, 0/1 data bit, A released ack, L driven-low ack, P stop)
	typedef struct {
		bit          is_cfg;
		kind_t       kind;
		logic [7:0]  payload;
		bit          first;
		bit          last;
		string       golden;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic       m_axis_tlast;

	bus_sym_t   symbols_due[$];
	logic [7:0] addr_shadow = ADDR_RESET;
	bit         no_stall;
	int         fail_count;
	int         reqs_sent;
	int         burst_bytes;
	int         symbols_seen;
	int         addr_writes;

	dir_row_t dir_rows [21] = '{
		'{0, KIND_CMD,   8'h00, 0, 0, "S01111000A00000000A00000000LP"},
		'{0, KIND_DATA,  8'hFF, 0, 0, "S01111000A01000000A11111111AP"},
		'{0, KIND_RAW,   8'hA5, 0, 0, "S10100101AP"},
		'{0, KIND_RAW,   8'h00, 1, 1, "S00000000AP"},
		'{0, KIND_BURST, 8'h81, 1, 0, "S01111000A01000000A10000001A"},
		'{0, KIND_BURST, 8'h5A, 0, 0, "01011010A"},
		'{0, KIND_BURST, 8'hFF, 0, 1, "11111111AP"},
		'{0, KIND_BURST, 8'h00, 1, 1, "S01111000A01000000A00000000AP"},
		'{0, KIND_BURST, 8'h00, 0, 0, "00000000A"},
		'{0, KIND_CMD,   8'hFF, 1, 1, "S01111000A00000000A11111111LP"},
		'{0, KIND_DATA,  8'h3C, 1, 0, ""},
		'{0, KIND_RAW,   8'h7E, 0, 1, ""},
		'{1, KIND_CMD,   8'h00, 0, 0, ""},
		'{0, KIND_CMD,   8'hFF, 0, 0, "S00000000A00000000A11111111LP"},
		'{0, KIND_BURST, 8'h01, 1, 0, ""},
		'{0, KIND_BURST, 8'h80, 0, 1, ""},
		'{1, KIND_CMD,   8'hFF, 0, 0, ""},
		'{0, KIND_DATA,  8'h00, 0, 0, "S11111111A01000000A00000000AP"},
		'{0, KIND_RAW,   8'h80, 0, 0, ""},
		'{0, KIND_BURST, 8'hC3, 1, 1, ""},
		'{0, KIND_CMD,   8'h01, 1, 0, ""}
	};

	i2c_display_write_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] payload
		.s_axis_tuser  (s_axis_tuser),   // [1:0] kind, [2] first_of_burst
		.s_axis_tlast  (s_axis_tlast),   // last_of_burst
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [0] bit_value, [7:1] zero
		.m_axis_tuser  (m_axis_tuser),   // [2:0] symbol
		.m_axis_tlast  (m_axis_tlast)    // end_of_run
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void add_sym(sym_t s, logic b);
		bus_sym_t e;
		e.sym  = s;
		e.bitv = b;
		e.eor  = 1'b0;
		symbols_due.push_back(e);
	endfunction

	// data bits go out msb first
	function automatic void add_byte(logic [7:0] b);
		for (int i = 7; i >= 0; i--)
			add_sym(SYM_BIT, b[i]);
	endfunction

	function automatic void add_header(logic [7:0] ctrl);
		add_sym(SYM_START, 1'b0);
		add_byte(addr_shadow);
		add_sym(SYM_ACK_REL, 1'b0);
		add_byte(ctrl);
		add_sym(SYM_ACK_REL, 1'b0);
	endfunction

	function automatic void predict_symbols(kind_t k, logic [7:0] pl, bit first, bit last);
		case (k)
			KIND_CMD: begin
				add_header(CTRL_CMD);
				add_byte(pl);
				add_sym(SYM_ACK_LOW, 1'b0);   // master holds SDA low after a command
				add_sym(SYM_STOP, 1'b0);
			end
			KIND_DATA: begin
				add_header(CTRL_DATA);
				add_byte(pl);
				add_sym(SYM_ACK_REL, 1'b0);
				add_sym(SYM_STOP, 1'b0);
			end
			KIND_RAW: begin
				// burst flags are don't-care here
				add_sym(SYM_START, 1'b0);
				add_byte(pl);
				add_sym(SYM_ACK_REL, 1'b0);
				add_sym(SYM_STOP, 1'b0);
			end
			default: begin
				// burst byte: no check that a burst is open
				if (first)
					add_header(CTRL_DATA);
				add_byte(pl);
				add_sym(SYM_ACK_REL, 1'b0);
				if (last)
					add_sym(SYM_STOP, 1'b0);
			end
		endcase
		symbols_due[symbols_due.size() - 1].eor = 1'b1;
	endfunction

	// expand a golden symbol string into due symbols
	function automatic void load_golden(string g);
		for (int i = 0; i < g.len(); i++) begin
			case (g[i])
				"S": add_sym(SYM_START, 1'b0);
				"0": add_sym(SYM_BIT, 1'b0);
				"1": add_sym(SYM_BIT, 1'b1);
				"A": add_sym(SYM_ACK_REL, 1'b0);
				"L": add_sym(SYM_ACK_LOW, 1'b0);
				default: add_sym(SYM_STOP, 1'b0);
			endcase
		end
		symbols_due[symbols_due.size() - 1].eor = 1'b1;
	endfunction

	// ---------------------------------------------------------------- drivers

	// one request item; valid stays high into the next call unless it idles
	task automatic send_req(kind_t k, logic [7:0] pl, bit first, bit last, string g);
		while (!no_stall && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pl;
		s_axis_tuser  <= {first, k};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (g.len() != 0)
			load_golden(g);
		else
			predict_symbols(k, pl, first, last);
		reqs_sent++;
		if (k == KIND_BURST)
			burst_bytes++;
	endtask

	// hold off until every due symbol has come out
	task automatic drain_symbols();
		s_axis_tvalid <= 1'b0;
		while (symbols_due.size() != 0)
			@(posedge clk);
	endtask

	// device address write, only with the sequencer idle
	task automatic write_addr(logic [7:0] a);
		drain_symbols();
		cfg_valid <= 1'b1;
		cfg_data  <= a;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid   <= 1'b0;
		addr_shadow  = a;
		addr_writes++;
	endtask

	// ---------------------------------------------------------------- symbol checker

	always @(posedge clk) begin
		bus_sym_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			symbols_seen++;
			if (symbols_due.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected symbol item: sym=%0d data=%02h last=%0b",
					$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
			end else begin
				e = symbols_due.pop_front();
				if (m_axis_tuser !== e.sym || m_axis_tdata !== {7'd0, e.bitv} ||
				    m_axis_tlast !== e.eor) begin
					fail_count++;
					$display("%0t: mismatch: exp sym=%0d data=%02h last=%0b,",
						$time, e.sym, {7'd0, e.bitv}, e.eor,
						" got sym=%0d data=%02h last=%0b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end
			end
		end
		m_axis_tready <= no_stall || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// ---------------------------------------------------------------- watchdog

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("i2c_display_write_sequencer verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		int n;
		int len;
		int r;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 8'h00;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = 3'd0;
		s_axis_tlast  = 1'b0;
		no_stall      = 1'b0;
		fail_count    = 0;
		reqs_sent     = 0;
		burst_bytes   = 0;
		symbols_seen  = 0;
		addr_writes   = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first rows run at the reset address
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_addr(dir_rows[i].payload);
			else
				send_req(dir_rows[i].kind, dir_rows[i].payload,
					dir_rows[i].first, dir_rows[i].last, dir_rows[i].golden);
		end

		// random phases; phase 2 runs with no idling on either side
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0:       write_addr(8'h00);
				1:       write_addr(8'hFF);
				default: write_addr(8'($urandom_range(255)));
			endcase
			no_stall = (ph == 2);
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 45) begin
					// well-formed burst with random bytes
					len = $urandom_range(1, 6);
					if (len > PHASE_ITEMS - n)
						len = PHASE_ITEMS - n;
					for (int j = 0; j < len; j++)
						send_req(KIND_BURST, 8'($urandom_range(255)),
							j == 0, j == len - 1, "");
					n += len;
				end else if (r < 85) begin
					// single request, flags as noise
					send_req(kind_t'($urandom_range(2)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 1'($urandom_range(1)), "");
					n++;
				end else begin
					// stray burst byte, any flags
					send_req(KIND_BURST, 8'($urandom_range(255)),
						1'($urandom_range(1)), 1'($urandom_range(1)), "");
					n++;
				end
			end
			no_stall = 1'b0;
		end

		drain_symbols();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d requests (%0d burst bytes) under %0d address writes",
			reqs_sent, burst_bytes, addr_writes);
		$display("checked %0d bus symbol items", symbols_seen);
		if (fail_count == 0)
			$display("i2c_display_write_sequencer verification clean");
		else
			$display("i2c_display_write_sequencer verification failed");
		$finish;
	end

endmodule

[i2c_display_write_sequencer.f]
sv/i2cdws_pkg.sv
sv/i2cdws_dp.sv
sv/i2cdws_ctrl.sv
sv/i2c_display_write_sequencer.sv
tb/sv/tb_i2c_display_write_sequencer.sv
